>>> src/gte_pkg.sv
// ----------------------------------------------------------------------------
// gte_pkg: shared types and constants of the tunnel encapsulator
// header layout constants, queue word format and the outer header byte table
// ----------------------------------------------------------------------------
`default_nettype none

package gte_pkg;

  localparam int ETH_HEADER_BYTES = 14;

  // outer header sizes
  localparam int ENCAP_BYTES     = 36;
  localparam int ENCAP_EXT_BYTES = 44;
  localparam int HDR_IDX_W       = $clog2(ENCAP_EXT_BYTES);

  // header field constants
  localparam logic [7:0]  IPV4_VER_IHL          = 8'h45;
  localparam logic [15:0] IP_ID                 = 16'h0513;
  localparam logic [7:0]  IP_TTL                = 8'd64;
  localparam logic [7:0]  IP_PROTO_UDP          = 8'd17;
  localparam logic [2:0]  GTP_U_VER             = 3'd1;
  localparam logic        GTP_PT_FLAG           = 1'b1;
  localparam logic [7:0]  GTP_MSG_TPDU          = 8'hFF;
  localparam logic [7:0]  GTP_EXT_PDU_SESSION   = 8'h85;
  localparam logic [7:0]  GTP_EXT_LEN_ONE       = 8'd1;
  localparam logic [15:0] IP_UDP_HDR_BYTES      = 16'd20;
  localparam logic [15:0] IP_UDP_GTP_HDR_BYTES  = 16'd36;

  // queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_ECHO      = 2'd0,
    CMD_HDR_SHORT = 2'd1,
    CMD_HDR_FULL  = 2'd2
  } cmd_kind_t;

  // one queued command: an echoed byte, or a header insertion job
  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data;  // echoed byte, or tos and second held byte
    logic [7:0] held;  // first held byte of a header job
    logic       last;
    logic       gate;
  } q_entry_t;

  // per-frame tunnel metadata held by the front
  typedef struct packed {
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [31:0] teid;
    logic [15:0] port;
    logic [5:0]  qfi;
    logic [3:0]  pdu_kind;
    logic        ext;
    logic [15:0] ip_len;
  } tunnel_meta_t;

  function automatic logic [7:0] hdr_byte(input logic [HDR_IDX_W-1:0] idx,
                                          input logic [7:0] tos,
                                          input tunnel_meta_t meta);
    logic [15:0] udp_len;
    logic [15:0] gtp_len;
    logic [7:0]  res;
    udp_len = meta.ip_len - IP_UDP_HDR_BYTES;
    gtp_len = meta.ip_len - IP_UDP_GTP_HDR_BYTES;
    res = 8'h00;
    unique case (idx)
      6'd0:  res = IPV4_VER_IHL;
      6'd1:  res = tos;
      6'd2:  res = meta.ip_len[15:8];
      6'd3:  res = meta.ip_len[7:0];
      6'd4:  res = IP_ID[15:8];
      6'd5:  res = IP_ID[7:0];
      6'd8:  res = IP_TTL;
      6'd9:  res = IP_PROTO_UDP;
      6'd12: res = meta.src_ip[31:24];
      6'd13: res = meta.src_ip[23:16];
      6'd14: res = meta.src_ip[15:8];
      6'd15: res = meta.src_ip[7:0];
      6'd16: res = meta.dst_ip[31:24];
      6'd17: res = meta.dst_ip[23:16];
      6'd18: res = meta.dst_ip[15:8];
      6'd19: res = meta.dst_ip[7:0];
      6'd20: res = meta.port[15:8];
      6'd21: res = meta.port[7:0];
      6'd22: res = meta.port[15:8];
      6'd23: res = meta.port[7:0];
      6'd24: res = udp_len[15:8];
      6'd25: res = udp_len[7:0];
      6'd28: res = {GTP_U_VER, GTP_PT_FLAG, 1'b0, meta.ext, 2'b00};
      6'd29: res = GTP_MSG_TPDU;
      6'd30: res = gtp_len[15:8];
      6'd31: res = gtp_len[7:0];
      6'd32: res = meta.teid[31:24];
      6'd33: res = meta.teid[23:16];
      6'd34: res = meta.teid[15:8];
      6'd35: res = meta.teid[7:0];
      6'd39: res = GTP_EXT_PDU_SESSION;
      6'd40: res = GTP_EXT_LEN_ONE;
      6'd41: res = {meta.pdu_kind, 4'h0};
      6'd42: res = {2'b00, meta.qfi};
      default: res = 8'h00;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

>>> src/gte_queue.sv
// ----------------------------------------------------------------------------
// gte_queue: command queue between front and back
// small register fifo with a fill count; push only when not full
// ----------------------------------------------------------------------------
`default_nettype none

module gte_queue (
  input  wire                clk,
  input  wire                rst,
  input  wire                push,
  input  gte_pkg::q_entry_t  push_data,
  output logic               full,
  input  wire                pop,
  output logic               head_valid,
  output gte_pkg::q_entry_t  head
);
  import gte_pkg::*;

  q_entry_t             mem [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr;
  logic [Q_PTR_W-1:0]   rd_ptr;
  logic [Q_CNT_W-1:0]   count;
  logic                 do_push;
  logic                 do_pop;

  assign full       = (count == Q_CNT_W'(Q_DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + Q_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + Q_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + Q_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - Q_CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> src/gte_front.sv
// ----------------------------------------------------------------------------
// gte_front: input side of the tunnel encapsulator
// tracks the byte position, latches frame metadata and queues commands
// ----------------------------------------------------------------------------
`default_nettype none

module gte_front (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    cfg_we,
  input  wire                    cfg_ext,
  input  wire                    in_valid,
  output logic                   in_stall,
  input  wire  [7:0]             data_byte,
  input  wire                    last_byte,
  input  wire  [15:0]            frame_length,
  input  wire  [31:0]            tunnel_src_ip,
  input  wire  [31:0]            tunnel_dst_ip,
  input  wire  [31:0]            tunnel_id,
  input  wire  [15:0]            udp_port,
  input  wire  [5:0]             flow_qfi,
  input  wire  [3:0]             session_pdu_type,
  input  wire                    q_full,
  output logic                   q_push,
  output gte_pkg::q_entry_t      q_data,
  output gte_pkg::tunnel_meta_t  meta,
  input  wire                    hdr_done
);
  import gte_pkg::*;

  logic         ext_reg;
  logic [15:0]  byte_index;
  logic         passthrough_flag;
  logic         hdr_pending;
  logic [7:0]   hold0;
  logic         accept;
  logic         first;
  logic [16:0]  len_sum;
  logic         too_long;
  logic         pt_now;
  logic         at_hold0;
  logic         at_hold1;
  logic         in_eth;

  assign first    = (byte_index == '0);
  assign in_stall = q_full || (first && hdr_pending);
  assign accept   = in_valid && !in_stall;

  assign len_sum  = {1'b0, frame_length}
                  + (ext_reg ? 17'(ENCAP_EXT_BYTES - ETH_HEADER_BYTES)
                             : 17'(ENCAP_BYTES - ETH_HEADER_BYTES));
  assign too_long = (frame_length < 16'(ETH_HEADER_BYTES)) || len_sum[16];
  assign pt_now   = first ? too_long : passthrough_flag;
  assign in_eth   = (byte_index < 16'(ETH_HEADER_BYTES));
  assign at_hold0 = (byte_index == 16'(ETH_HEADER_BYTES));
  assign at_hold1 = (byte_index == 16'(ETH_HEADER_BYTES + 1));

  always_comb begin
    q_data      = '0;
    q_data.kind = CMD_ECHO;
    q_data.data = data_byte;
    q_data.held = hold0;
    q_data.last = last_byte;
    q_data.gate = 1'b1;
    q_push      = accept;
    if (pt_now) begin
      q_data.gate = 1'b0;
    end else if (in_eth) begin
      q_data.gate = 1'b1;
    end else if (at_hold0) begin
      // frame ends on the first held byte: tos reads as zero
      q_data.kind = CMD_HDR_SHORT;
      q_data.data = 8'h00;
      q_data.held = data_byte;
      q_push      = accept && last_byte;
    end else if (at_hold1) begin
      q_data.kind = CMD_HDR_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && first) begin
      meta.src_ip   <= tunnel_src_ip;
      meta.dst_ip   <= tunnel_dst_ip;
      meta.teid     <= tunnel_id;
      meta.port     <= udp_port;
      meta.qfi      <= flow_qfi;
      meta.pdu_kind <= session_pdu_type;
      meta.ext      <= ext_reg;
      if (!too_long) begin
        meta.ip_len <= len_sum[15:0];
      end
    end
    if (accept && !pt_now && at_hold0) begin
      hold0 <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ext_reg          <= 1'b0;
      byte_index       <= '0;
      passthrough_flag <= 1'b0;
      hdr_pending      <= 1'b0;
    end else begin
      if (cfg_we) begin
        ext_reg <= cfg_ext;
      end
      if (accept) begin
        if (first) begin
          passthrough_flag <= too_long;
        end
        if (last_byte) begin
          byte_index <= '0;
        end else if (byte_index != 16'hFFFF) begin
          byte_index <= byte_index + 16'd1;
        end
      end
      if (q_push && q_data.kind != CMD_ECHO) begin
        hdr_pending <= 1'b1;
      end else if (hdr_done) begin
        hdr_pending <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

>>> src/gte_back.sv
// ----------------------------------------------------------------------------
// gte_back: output side of the tunnel encapsulator
// echoes queued bytes and sequences the outer header insertion
// ----------------------------------------------------------------------------
`default_nettype none

module gte_back (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    q_valid,
  input  gte_pkg::q_entry_t      q_head,
  output logic                   q_pop,
  input  gte_pkg::tunnel_meta_t  meta,
  output logic                   hdr_done,
  output logic                   out_valid,
  input  wire                    out_stall,
  output logic [7:0]             out_byte,
  output logic                   out_last,
  output logic                   tunnel_gate
);
  import gte_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_HDR   = 4'b0010,
    ST_HELD0 = 4'b0100,
    ST_HELD1 = 4'b1000
  } back_state_t;

  back_state_t           state;
  back_state_t           state_next;
  logic [HDR_IDX_W-1:0]  hdr_idx;
  logic [HDR_IDX_W-1:0]  hdr_end;
  logic [7:0]            job_tos;
  logic [7:0]            job_held0;
  logic                  job_last;
  logic                  job_short;
  logic                  adv;
  logic                  produce;
  logic [7:0]            byte_next;
  logic                  last_next;
  logic                  gate_next;

  assign adv     = !out_valid || !out_stall;
  assign hdr_end = meta.ext ? HDR_IDX_W'(ENCAP_EXT_BYTES - 1) : HDR_IDX_W'(ENCAP_BYTES - 1);
  assign q_pop   = (state == ST_IDLE) && q_valid && adv;
  assign produce = (state != ST_IDLE) || q_valid;

  always_comb begin
    state_next = state;
    byte_next  = q_head.data;
    last_next  = q_head.last;
    gate_next  = q_head.gate;
    hdr_done   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (q_head.kind != CMD_ECHO) begin
          byte_next = IPV4_VER_IHL;
          last_next = 1'b0;
          gate_next = 1'b1;
          if (q_pop) begin
            state_next = ST_HDR;
          end
        end
      end
      ST_HDR: begin
        byte_next = hdr_byte(hdr_idx, job_tos, meta);
        last_next = 1'b0;
        gate_next = 1'b1;
        if (adv && hdr_idx == hdr_end) begin
          state_next = ST_HELD0;
        end
      end
      ST_HELD0: begin
        byte_next = job_held0;
        last_next = job_short;
        gate_next = 1'b1;
        if (adv) begin
          state_next = job_short ? ST_IDLE : ST_HELD1;
          hdr_done   = job_short;
        end
      end
      ST_HELD1: begin
        byte_next = job_tos;
        last_next = job_last;
        gate_next = 1'b1;
        if (adv) begin
          state_next = ST_IDLE;
          hdr_done   = 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_tos   <= q_head.data;
      job_held0 <= q_head.held;
      job_last  <= q_head.last;
      job_short <= (q_head.kind == CMD_HDR_SHORT);
    end
    if (q_pop) begin
      hdr_idx <= HDR_IDX_W'(1);
    end else if (state == ST_HDR && adv) begin
      hdr_idx <= hdr_idx + HDR_IDX_W'(1);
    end
    if (adv && produce) begin
      out_byte    <= byte_next;
      out_last    <= last_next;
      tunnel_gate <= gate_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (adv) begin
        out_valid <= produce;
      end
    end
  end

endmodule

`default_nettype wire

>>> src/gtpu_tunnel_encapsulator.sv
// ----------------------------------------------------------------------------
// gtpu_tunnel_encapsulator: ipv4/udp/gtp-u tunnel header insertion
// byte-stream encapsulator with a front classifier, a queue and a back sequencer
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid/in_stall, one frame byte per word with last_byte;
//     frame_length and the tunnel metadata are sampled on the first word
//   output channel: out_valid/out_stall, one output byte per word with out_last
//     and tunnel_gate (1 encapsulated, 0 passed unchanged)
//   config channel: cfg_valid/cfg_ready, add_session_ext; always ready, and
//     the value is latched per frame on its first word
//   path: an accepted word is written into the command queue, and the back
//     moves it from the queue head into the output register
//   throughput: one word per cycle for ethernet header and payload bytes while
//     no stall holds the flow; the two bytes after the ethernet header trigger
//     a header job that the back sequencer plays out as 36 or 44 header bytes
//     plus the two held bytes (one held byte fewer when the frame ends on the
//     first of them), one byte per cycle while out_stall is low
//   in_stall rises when the 4-word command queue is full, and on the first
//     word of a frame while the previous frame's header job is queued or running
//   a stalled receiver holds the output register; the queue fills behind it
//   reset clears the byte position, the queue and the output register
// ----------------------------------------------------------------------------
`default_nettype none

module gtpu_tunnel_encapsulator (
  input  wire          clk,
  input  wire          rst,
  // configuration write
  input  wire          cfg_valid,
  output logic         cfg_ready,
  input  wire          add_session_ext,
  // input words
  input  wire          in_valid,
  output logic         in_stall,
  input  wire  [7:0]   data_byte,
  input  wire          last_byte,
  input  wire  [15:0]  frame_length,
  input  wire  [31:0]  tunnel_src_ip,
  input  wire  [31:0]  tunnel_dst_ip,
  input  wire  [31:0]  tunnel_id,
  input  wire  [15:0]  udp_port,
  input  wire  [5:0]   flow_qfi,
  input  wire  [3:0]   session_pdu_type,
  // output words
  output logic         out_valid,
  input  wire          out_stall,
  output logic [7:0]   out_byte,
  output logic         out_last,
  output logic         tunnel_gate
);
  import gte_pkg::*;

  // queue signals
  logic          q_push;
  q_entry_t      q_push_data;
  logic          q_full;
  logic          q_pop;
  logic          q_valid;
  q_entry_t      q_head;

  // frame metadata owned by the front, read by the back during header jobs
  tunnel_meta_t  meta;
  logic          hdr_done;

  // the single register can always be written
  assign cfg_ready = 1'b1;

  gte_front u_front (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_ext          (add_session_ext),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .data_byte        (data_byte),
    .last_byte        (last_byte),
    .frame_length     (frame_length),
    .tunnel_src_ip    (tunnel_src_ip),
    .tunnel_dst_ip    (tunnel_dst_ip),
    .tunnel_id        (tunnel_id),
    .udp_port         (udp_port),
    .flow_qfi         (flow_qfi),
    .session_pdu_type (session_pdu_type),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_data           (q_push_data),
    .meta             (meta),
    .hdr_done         (hdr_done)
  );

  // decouples classification from header playout
  gte_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  (q_push_data),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  gte_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .meta         (meta),
    .hdr_done     (hdr_done),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_last     (out_last),
    .tunnel_gate  (tunnel_gate)
  );

endmodule

`default_nettype wire

>>> src/gte_checker.sv
// ----------------------------------------------------------------------------
// gte_checker: port-level checks of the tunnel encapsulator
// output framing and header placement, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module gte_checker (
  input wire        clk,
  input wire        rst,
  input wire        out_valid,
  input wire        out_stall,
  input wire  [7:0] out_byte,
  input wire        out_last,
  input wire        tunnel_gate
);
  import gte_pkg::*;

  logic        out_take;
  logic        mid_frame;
  logic        frame_gate;
  logic [4:0]  pos;

  assign out_take = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_frame  <= 1'b0;
      frame_gate <= 1'b0;
      pos        <= '0;
    end else if (out_take) begin
      mid_frame  <= !out_last;
      frame_gate <= tunnel_gate;
      if (out_last) begin
        pos <= '0;
      end else if (pos != 5'd31) begin
        pos <= pos + 5'd1;
      end
    end
  end

  // output register holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("output word changed while stalled");

  // the output register is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // one gate for every word of a frame
  a_gate_steady: assert property (@(posedge clk) disable iff (rst)
    out_valid && mid_frame |-> tunnel_gate == frame_gate)
    else $error("tunnel gate changed inside a frame");

  // the outer ipv4 header starts right after the ethernet header
  a_outer_start: assert property (@(posedge clk) disable iff (rst)
    out_valid && tunnel_gate && pos == 5'(ETH_HEADER_BYTES) |-> out_byte == IPV4_VER_IHL)
    else $error("outer header misplaced");

endmodule

bind gtpu_tunnel_encapsulator gte_checker u_gte_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_byte     (out_byte),
  .out_last     (out_last),
  .tunnel_gate  (tunnel_gate)
);

`default_nettype wire
